// ===== src/pdpm_pkg.sv =====
// ----------------------------------------------------------------------------
// PWM duty/period meter package
// Field widths, register indexes, reset values and scale constants.
// ----------------------------------------------------------------------------
`default_nettype none

package pdpm_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  localparam int DUTY_W     = 7;
  localparam int PERIOD_W   = 32;
  localparam int FREQ_W     = 18;
  localparam int CLK_W      = 18;
  localparam int TIMEOUT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SCALE_W    = 20;

  localparam logic [CFG_IDX_W-1:0] REG_CLOCK_KHZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 2'd1;

  localparam logic [CLK_W-1:0]     CLOCK_KHZ_RST = 18'd120000;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = 32'd5000000;

  localparam logic [SCALE_W-1:0] DUTY_SCALE = 20'd100;
  localparam logic [SCALE_W-1:0] NS_SCALE   = 20'd1000000;
  localparam logic [DUTY_W-1:0]  DUTY_FULL  = 7'd100;

endpackage

`default_nettype wire

// ===== src/pdpm_ifs.sv =====
// ----------------------------------------------------------------------------
// PWM duty/period meter channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdpm_in_if;
  logic valid;
  logic ready;
  logic pwm_level;
  modport source (output valid, output pwm_level, input ready);
  modport sink   (input valid, input pwm_level, output ready);
endinterface

interface pdpm_out_if;
  logic                          valid;
  logic                          ready;
  logic [pdpm_pkg::DUTY_W-1:0]   duty_percent;
  logic [pdpm_pkg::PERIOD_W-1:0] period_ns;
  logic [pdpm_pkg::FREQ_W-1:0]   freq_khz;
  logic                          indeterminate;
  modport source (output valid, output duty_percent, output period_ns, output freq_khz,
                  output indeterminate, input ready);
  modport sink   (input valid, input duty_percent, input period_ns, input freq_khz,
                  input indeterminate, output ready);
endinterface

interface pdpm_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pdpm_pkg::CFG_IDX_W-1:0]  index;
  logic [pdpm_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== src/pdpm_mul.sv =====
// ----------------------------------------------------------------------------
// PWM meter serial multiplier
// Shift-add multiply, one bit of the scale operand per cycle, MSB first.
// ----------------------------------------------------------------------------
`default_nettype none

module pdpm_mul #(
  parameter int AW = 32,
  parameter int KW = 20
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   a,
  input  logic [KW-1:0]   k,
  output logic            done,
  output logic [AW+KW-1:0] prod
);

  localparam int PW  = AW + KW;
  localparam int CNW = $clog2(KW + 1);

  logic [AW-1:0]  a_r;
  logic [KW-1:0]  k_r;
  logic [CNW-1:0] cnt;
  logic           busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(KW);
        a_r  <= a;
        k_r  <= k;
        prod <= '0;
      end else if (busy) begin
        prod <= {prod[PW-2:0], 1'b0} + (k_r[KW-1] ? PW'(a_r) : '0);
        k_r  <= {k_r[KW-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pdpm_div.sv =====
// ----------------------------------------------------------------------------
// PWM meter serial divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pdpm_div #(
  parameter int NW = 52,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);

  localparam int CNW = $clog2(NW + 1);

  logic [DW-1:0]  den_r;
  logic [DW-1:0]  rem;
  logic [CNW-1:0] cnt;
  logic           busy;
  logic [DW:0]    trial;
  logic [DW:0]    diff;
  logic           ge;

  assign trial = {rem, quo[NW-1]};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= CNW'(NW);
        den_r <= den;
        rem   <= '0;
        quo   <= num;
      end else if (busy) begin
        rem <= ge ? diff[DW-1:0] : trial[DW-1:0];
        quo <= {quo[NW-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/pwm_duty_period_meter.sv =====
// ----------------------------------------------------------------------------
// PWM duty/period meter
// Edge capture of a sampled PWM pin; duty, period and frequency computed
// by a shared serial multiplier and serial divider.
// ----------------------------------------------------------------------------
// A sample that completes nothing leaves the input ready for the next sample.
// A timeout report passes through S_EMIT into the result registers; the input
// is ready again once S_EMIT has handed it over. A completed measurement runs
// two 20-step multiplies and three divides of COUNT_WIDTH+20 steps, then passes
// through S_EMIT, and a result not taken stalls the input.
// Reset (rst, synchronous) restores register defaults and clears the capture state.
`default_nettype none

module pwm_duty_period_meter #(
  parameter int COUNT_WIDTH = pdpm_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  pdpm_cfg_if.sink    cfg,
  pdpm_in_if.sink     samples,
  pdpm_out_if.source  results
);

  import pdpm_pkg::*;

  localparam int CW     = COUNT_WIDTH;
  localparam int PROD_W = CW + SCALE_W;
  localparam int DEN_W  = (CW > CLK_W) ? CW : CLK_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  localparam logic [1:0] OP_DUTY = 2'd0;
  localparam logic [1:0] OP_PNS  = 2'd1;
  localparam logic [1:0] OP_FREQ = 2'd2;

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;

  logic [CLK_W-1:0]     clock_khz;
  logic [TIMEOUT_W-1:0] timeout_ticks;

  logic [1:0]           phase;
  logic                 prev_level;
  logic [CW-1:0]        elapsed;
  logic [CW-1:0]        high_time;
  logic [TIMEOUT_W-1:0] timeout_count;

  logic [1:0]           st;
  logic [1:0]           op;
  logic [CW-1:0]        period_cap;

  logic [DUTY_W-1:0]    duty_r;
  logic [PERIOD_W-1:0]  pns_r;
  logic [FREQ_W-1:0]    freq_r;
  logic                 ind_r;

  logic                 res_valid;
  logic [DUTY_W-1:0]    res_duty;
  logic [PERIOD_W-1:0]  res_pns;
  logic [FREQ_W-1:0]    res_freq;
  logic                 res_ind;

  logic                 accept;
  logic                 level;
  logic                 rise;
  logic                 fall;
  logic [CW-1:0]        elapsed_inc;
  logic [TIMEOUT_W-1:0] tc_inc;
  logic                 done_now;
  logic                 timeout_now;
  logic [CLK_W-1:0]     clk_eff;
  logic [CW-1:0]        period_eff;

  logic                 mul_start;
  logic [CW-1:0]        mul_a;
  logic [SCALE_W-1:0]   mul_k;
  logic                 mul_done;
  logic [PROD_W-1:0]    mul_prod;

  logic                 div_start;
  logic [PROD_W-1:0]    div_num;
  logic [DEN_W-1:0]     div_den;
  logic                 div_done;
  logic [PROD_W-1:0]    div_quo;

  assign cfg.ready     = 1'b1;
  assign samples.ready = (st == S_IDLE);
  assign accept        = samples.valid && samples.ready;
  assign level         = samples.pwm_level;

  assign rise        = level && !prev_level;
  assign fall        = !level && prev_level;
  assign elapsed_inc = (elapsed == {CW{1'b1}}) ? elapsed : elapsed + 1'b1;
  assign tc_inc      = (timeout_count == {TIMEOUT_W{1'b1}}) ? timeout_count
                                                            : timeout_count + 1'b1;
  assign done_now    = (phase == PH_LOW) && rise;
  assign timeout_now = tc_inc >= timeout_ticks;

  assign clk_eff    = (clock_khz == '0) ? CLK_W'(1) : clock_khz;
  assign period_eff = (period_cap == '0) ? CW'(1) : period_cap;

  // operand selection for the shared units
  assign mul_start = (accept && done_now) || (st == S_DIV && div_done && op == OP_DUTY);
  assign mul_a     = (st == S_IDLE) ? high_time : period_cap;
  assign mul_k     = (st == S_IDLE) ? DUTY_SCALE : NS_SCALE;

  assign div_start = mul_done || (st == S_DIV && div_done && op == OP_PNS);
  assign div_num   = (st == S_MUL) ? mul_prod : PROD_W'(clk_eff);
  assign div_den   = (st == S_MUL && op == OP_PNS) ? DEN_W'(clk_eff) : DEN_W'(period_eff);

  pdpm_mul #(
    .AW (CW),
    .KW (SCALE_W)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .k     (mul_k),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  pdpm_div #(
    .NW (PROD_W),
    .DW (DEN_W)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_khz     <= CLOCK_KHZ_RST;
      timeout_ticks <= TIMEOUT_RST;
      phase         <= PH_WAIT;
      prev_level    <= 1'b0;
      elapsed       <= '0;
      high_time     <= '0;
      timeout_count <= '0;
      st            <= S_IDLE;
      op            <= OP_DUTY;
      res_valid     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          REG_CLOCK_KHZ: clock_khz     <= cfg.data[CLK_W-1:0];
          REG_TIMEOUT:   timeout_ticks <= cfg.data[TIMEOUT_W-1:0];
          default: ;
        endcase
      end

      if (res_valid && results.ready && st != S_EMIT) begin
        res_valid <= 1'b0;
      end

      case (st)
        S_IDLE: begin
          if (accept) begin
            prev_level <= level;
            if (done_now || timeout_now) begin
              phase         <= PH_WAIT;
              elapsed       <= '0;
              high_time     <= '0;
              timeout_count <= '0;
              if (done_now) begin
                period_cap <= elapsed_inc;
                op         <= OP_DUTY;
                st         <= S_MUL;
              end else begin
                duty_r <= level ? DUTY_FULL : '0;
                pns_r  <= '0;
                freq_r <= '0;
                ind_r  <= 1'b1;
                st     <= S_EMIT;
              end
            end else begin
              timeout_count <= tc_inc;
              case (phase)
                PH_HIGH: begin
                  elapsed <= elapsed_inc;
                  if (fall) begin
                    high_time <= elapsed_inc;
                    phase     <= PH_LOW;
                  end
                end
                PH_LOW: elapsed <= elapsed_inc;
                default: begin
                  if (rise) begin
                    phase     <= PH_HIGH;
                    elapsed   <= '0;
                    high_time <= '0;
                  end else begin
                    phase <= PH_WAIT;
                  end
                end
              endcase
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            st <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            case (op)
              OP_DUTY: begin
                duty_r <= (div_quo > PROD_W'(DUTY_FULL)) ? DUTY_FULL : div_quo[DUTY_W-1:0];
                op     <= OP_PNS;
                st     <= S_MUL;
              end
              OP_PNS: begin
                pns_r <= (|div_quo[PROD_W-1:PERIOD_W]) ? {PERIOD_W{1'b1}}
                                                       : div_quo[PERIOD_W-1:0];
                op    <= OP_FREQ;
              end
              default: begin
                freq_r <= div_quo[FREQ_W-1:0];
                ind_r  <= 1'b0;
                st     <= S_EMIT;
              end
            endcase
          end
        end
        default: begin
          if (!res_valid || results.ready) begin
            res_valid <= 1'b1;
            res_duty  <= duty_r;
            res_pns   <= pns_r;
            res_freq  <= freq_r;
            res_ind   <= ind_r;
            st        <= S_IDLE;
          end
        end
      endcase
    end
  end

  assign results.valid         = res_valid;
  assign results.duty_percent  = res_duty;
  assign results.period_ns     = res_pns;
  assign results.freq_khz      = res_freq;
  assign results.indeterminate = res_ind;

endmodule

`default_nettype wire
